FILE: rtl/adc_vdd_temp_calibration_macros.svh
// Assertion helpers shared by the calibration block.
`ifndef ADC_VDD_TEMP_CALIBRATION_MACROS_SVH
`define ADC_VDD_TEMP_CALIBRATION_MACROS_SVH
`ifndef ASSERT_OFF
`define AVTC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AVTC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define AVTC_ASSERT(lbl, clk, rst, prop, msg)
`define AVTC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/avtc_pkg.sv
package avtc_pkg;

  localparam int MODE_W    = 2;
  localparam int SAMPLE_W  = 12;
  localparam int VALUE_W   = 17;
  localparam int STATUS_W  = 2;
  localparam int REG_W     = 12;
  localparam int REG_IDX_W = 2;
  localparam int SUPPLY_W  = 16;
  localparam int SUM_W     = 16;

  // Shared multiplier operand and product widths.
  localparam int MUL_AW = 24;
  localparam int MUL_BW = 16;
  localparam int MUL_PW = 40;

  // Divider: dividend, divisor and quotient widths, step counter width.
  localparam int DIV_UW = 46;
  localparam int DIV_DW = 29;
  localparam int DIV_QW = 18;
  localparam int DIV_CW = 5;
  localparam int DEN_W  = DIV_DW - 1;
  localparam int DIFF_W = 34;

  typedef logic [MODE_W-1:0]          mode_t;
  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic signed [VALUE_W-1:0]  value_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic [REG_W-1:0]           reg_t;
  typedef logic [REG_IDX_W-1:0]       reg_idx_t;
  typedef logic [SUPPLY_W-1:0]        supply_t;

  localparam mode_t MODE_REF   = 2'd0;
  localparam mode_t MODE_TEMP  = 2'd1;
  localparam mode_t MODE_BATT  = 2'd2;
  localparam mode_t MODE_SOLAR = 2'd3;

  localparam status_t STAT_OK        = 2'd0;
  localparam status_t STAT_EMPTY     = 2'd1;
  localparam status_t STAT_NO_SUPPLY = 2'd2;
  localparam status_t STAT_SPAN_ZERO = 2'd3;

  localparam reg_idx_t REG_VREF_CAL  = 2'd0;
  localparam reg_idx_t REG_TEMP_LO   = 2'd1;
  localparam reg_idx_t REG_TEMP_HI   = 2'd2;
  localparam reg_idx_t REG_BATT_GAIN = 2'd3;

  localparam reg_t RST_VREF_CAL  = 12'd1670;
  localparam reg_t RST_TEMP_LO   = 12'd680;
  localparam reg_t RST_TEMP_HI   = 12'd900;
  localparam reg_t RST_BATT_GAIN = 12'd512;

  // Calibration supply of 3.0 V in millivolts.
  localparam logic [MUL_BW-1:0] K_CAL_MV = 16'd3000;
  // 30 degrees in sixteenths of a degree.
  localparam logic signed [19:0] T_OFFSET = 20'sd480;

  localparam logic [MUL_PW-1:0] BATT_HALF  = 40'h0000080000;
  localparam logic [MUL_PW-1:0] SOLAR_HALF = 40'h0000000800;
  localparam int BATT_SHIFT  = 20;
  localparam int SOLAR_SHIFT = 12;

  localparam supply_t SUPPLY_MAX = 16'hFFFF;
  localparam value_t  VALUE_MAX  = 17'sh0FFFF;
  localparam value_t  VALUE_MIN  = 17'sh10000;

  typedef struct packed {
    logic                start;
    logic [DIV_UW-1:0]   dividend;
    logic [DIV_DW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic                ovf;
    logic [DIV_QW-1:0]   quo;
  } div_res_t;

endpackage

FILE: rtl/avtc_ifs.sv
interface avtc_in_if import avtc_pkg::*; ();
  logic    valid;
  logic    ready;
  mode_t   mode;
  sample_t sample;
  logic    burst_end;

  modport source (output valid, output mode, output sample, output burst_end, input ready);
  modport sink   (input valid, input mode, input sample, input burst_end, output ready);
endinterface

interface avtc_out_if import avtc_pkg::*; ();
  logic    valid;
  logic    ready;
  mode_t   kind;
  value_t  value;
  status_t status;

  modport source (output valid, output kind, output value, output status, input ready);
  modport sink   (input valid, input kind, input value, input status, output ready);
endinterface

FILE: rtl/avtc_div.sv
`include "adc_vdd_temp_calibration_macros.svh"

module avtc_div import avtc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_res_t res
);

  logic                running;
  logic                done;
  logic                ovf;
  logic [DIV_CW-1:0]   cnt;
  logic [DIV_DW-1:0]   rem;
  logic [DIV_DW-1:0]   dreg;
  logic [DIV_QW-1:0]   qs;
  logic [DIV_DW:0]     trial;
  logic                fits;
  logic [DIV_DW-1:0]   high_part;

  assign high_part = DIV_DW'(req.dividend[DIV_UW-1:DIV_QW]);
  assign trial     = {rem, qs[DIV_QW-1]};
  assign fits      = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      ovf     <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        // A quotient that cannot fit the result width is flagged at once.
        if (high_part >= req.divisor) begin
          ovf  <= 1'b1;
          done <= 1'b1;
        end else begin
          ovf     <= 1'b0;
          rem     <= high_part;
          qs      <= req.dividend[DIV_QW-1:0];
          dreg    <= req.divisor;
          cnt     <= DIV_CW'(DIV_QW);
          running <= 1'b1;
        end
      end else if (running) begin
        rem <= fits ? DIV_DW'(trial - {1'b0, dreg}) : trial[DIV_DW-1:0];
        qs  <= {qs[DIV_QW-2:0], fits};
        cnt <= cnt - DIV_CW'(1);
        if (cnt == DIV_CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.ovf  = ovf;
  assign res.quo  = qs;

  `AVTC_ASSERT(a_start_idle, clk, rst, req.start |-> !running, "divide started while busy")
  `AVTC_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "divide done held longer than a cycle")
  `AVTC_ASSERT(a_rem_bound, clk, rst, running |-> rem < dreg, "partial remainder out of range")

endmodule

FILE: rtl/adc_vdd_temp_calibration.sv
// A non-final burst item is taken without leaving the idle state; early results (held
// supply, errors) go from the idle state through the emit state to the output register.
// Battery and solar items use the shared multiplier; reference and temperature bursts use
// it in up to five steps and then the 18-step restoring divider. Input is not taken again
// until the item is finished. Synchronous reset restores register defaults and clears
// the measured supply, the open burst and the output valid flag.
`include "adc_vdd_temp_calibration_macros.svh"

module adc_vdd_temp_calibration import avtc_pkg::*; #(
  parameter int MAX_BURST = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  reg_idx_t cfg_index,
  input  reg_t     cfg_data,
  avtc_in_if.sink    in_ch,
  avtc_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_BURST);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_BURST - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_COMB, ST_PREP, ST_DIVGO, ST_DIV, ST_EMIT
  } state_t;

  reg_t vref_cal, temp_lo, temp_hi, batt_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      vref_cal  <= RST_VREF_CAL;
      temp_lo   <= RST_TEMP_LO;
      temp_hi   <= RST_TEMP_HI;
      batt_gain <= RST_BATT_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VREF_CAL:  vref_cal  <= cfg_data;
        REG_TEMP_LO:   temp_lo   <= cfg_data;
        REG_TEMP_HI:   temp_hi   <= cfg_data;
        REG_BATT_GAIN: batt_gain <= cfg_data;
      endcase
    end
  end

  state_t                     state;
  mode_t                      md;
  logic [2:0]                 mstep;
  logic [2:0]                 mstep_last;
  supply_t                    supply_mv;
  logic [SUM_W-1:0]           burst_sum;
  logic [CNT_W-1:0]           kept_count;
  logic                       first_seen;
  logic                       burst_kind;
  sample_t                    wsample;
  logic [SUM_W-1:0]           wsum;
  logic [CNT_W-1:0]           wcnt;
  logic                       sneg;
  reg_t                       smag;
  logic [MUL_PW-1:0]          prod;
  logic [31:0]                acc_a;
  logic [DEN_W-1:0]           acc_b;
  logic signed [DIV_UW-1:0]   num_reg;
  logic [DEN_W-1:0]           den_reg;
  logic                       neg_reg;
  logic [DIV_UW-1:0]          u_reg;
  logic [DIV_DW-1:0]          d_reg;
  mode_t                      res_kind;
  value_t                     res_value;
  status_t                    res_status;
  logic                       out_valid;
  mode_t                      out_kind;
  value_t                     out_value;
  status_t                    out_status;

  div_req_t div_req;
  div_res_t div_res;

  // Burst bookkeeping for the item on the input.
  logic              in_xfer;
  logic              new_burst;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]  cnt_next;
  logic signed [REG_W:0] span;
  logic              span_neg;
  reg_t              span_mag;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign new_burst   = !first_seen || (burst_kind != in_ch.mode[0]);
  assign span        = $signed({1'b0, temp_hi}) - $signed({1'b0, temp_lo});
  assign span_neg    = span[REG_W];
  assign span_mag    = span_neg ? REG_W'(-span) : span[REG_W-1:0];

  always_comb begin
    if (new_burst) begin
      sum_next = '0;
      cnt_next = '0;
    end else if (kept_count < CNT_LIMIT) begin
      sum_next = burst_sum + SUM_W'(in_ch.sample);
      cnt_next = kept_count + CNT_W'(1);
    end else begin
      sum_next = burst_sum;
      cnt_next = kept_count;
    end
  end

  // Shared multiplier operand selection.
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_p;

  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    mstep_last = 3'd0;
    case (md)
      MODE_BATT: begin
        mstep_last = 3'd1;
        if (mstep == 3'd0) begin
          mul_a = MUL_AW'(wsample);
          mul_b = MUL_BW'(batt_gain);
        end else begin
          mul_a = prod[MUL_AW-1:0];
          mul_b = supply_mv;
        end
      end
      MODE_SOLAR: begin
        mul_a = MUL_AW'(wsample);
        mul_b = supply_mv;
      end
      MODE_REF: begin
        mstep_last = 3'd1;
        if (mstep == 3'd0) begin
          mul_a = MUL_AW'(vref_cal);
          mul_b = MUL_BW'(wcnt);
        end else begin
          mul_a = prod[MUL_AW-1:0];
          mul_b = K_CAL_MV;
        end
      end
      default: begin
        mstep_last = 3'd4;
        case (mstep)
          3'd0: begin
            mul_a = MUL_AW'(wsum);
            mul_b = supply_mv;
          end
          3'd1: begin
            mul_a = MUL_AW'(temp_lo);
            mul_b = MUL_BW'(wcnt);
          end
          3'd3: begin
            mul_a = MUL_AW'(smag);
            mul_b = MUL_BW'(wcnt);
          end
          default: begin
            mul_a = prod[MUL_AW-1:0];
            mul_b = K_CAL_MV;
          end
        endcase
      end
    endcase
  end

  assign mul_p = MUL_PW'(mul_a) * MUL_PW'(mul_b);

  // Battery and solar scaling with rounding.
  logic [MUL_PW-1:0] lin_mv;
  supply_t           lin_sat;

  assign lin_mv  = (md == MODE_BATT) ? ((prod + BATT_HALF) >> BATT_SHIFT)
                                     : ((prod + SOLAR_HALF) >> SOLAR_SHIFT);
  assign lin_sat = (lin_mv > MUL_PW'(SUPPLY_MAX)) ? SUPPLY_MAX : lin_mv[SUPPLY_W-1:0];

  // Temperature numerator: 1280 * (supply*sum - 3000*count*cal_low), sign of span folded in.
  logic signed [DIFF_W-1:0]  a_ext, b_ext, diff;
  logic signed [DIV_UW-1:0]  diff_ext, num_temp, big_n;

  assign a_ext    = $signed(DIFF_W'(acc_a));
  assign b_ext    = $signed(DIFF_W'(acc_b));
  assign diff     = sneg ? (b_ext - a_ext) : (a_ext - b_ext);
  assign diff_ext = DIV_UW'(diff);
  assign num_temp = (diff_ext <<< 10) + (diff_ext <<< 8);
  assign big_n    = (num_reg <<< 1) + $signed(DIV_UW'(den_reg));

  // Final scaling of the quotient.
  supply_t                ref_mv;
  logic signed [19:0]     t_sum;
  logic signed [18:0]     floor_q;
  value_t                 t_sat;

  assign ref_mv  = (div_res.ovf || (div_res.quo > DIV_QW'(SUPPLY_MAX))) ? SUPPLY_MAX
                                                                   : div_res.quo[SUPPLY_W-1:0];
  assign floor_q = neg_reg ? $signed({1'b1, ~div_res.quo}) : $signed({1'b0, div_res.quo});
  assign t_sum   = T_OFFSET + 20'(floor_q);

  always_comb begin
    if (div_res.ovf) begin
      t_sat = neg_reg ? VALUE_MIN : VALUE_MAX;
    end else if (t_sum > 20'(VALUE_MAX)) begin
      t_sat = VALUE_MAX;
    end else if (t_sum < 20'(VALUE_MIN)) begin
      t_sat = VALUE_MIN;
    end else begin
      t_sat = t_sum[VALUE_W-1:0];
    end
  end

  assign div_req.start    = (state == ST_DIVGO);
  assign div_req.dividend = u_reg;
  assign div_req.divisor  = d_reg;

  avtc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      supply_mv  <= '0;
      burst_sum  <= '0;
      kept_count <= '0;
      first_seen <= 1'b0;
      burst_kind <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            md      <= in_ch.mode;
            wsample <= in_ch.sample;
            mstep   <= 3'd0;
            sneg    <= span_neg;
            smag    <= span_mag;
            res_kind   <= in_ch.mode;
            res_value  <= '0;
            res_status <= STAT_OK;
            if (in_ch.mode == MODE_BATT || in_ch.mode == MODE_SOLAR) begin
              if (supply_mv == '0) begin
                res_status <= STAT_NO_SUPPLY;
                state      <= ST_EMIT;
              end else begin
                state <= ST_MUL;
              end
            end else begin
              first_seen <= 1'b1;
              burst_kind <= in_ch.mode[0];
              burst_sum  <= sum_next;
              kept_count <= cnt_next;
              if (in_ch.burst_end) begin
                first_seen <= 1'b0;
                burst_sum  <= '0;
                kept_count <= '0;
                wsum       <= sum_next;
                wcnt       <= cnt_next;
                if (in_ch.mode == MODE_REF) begin
                  if (supply_mv != '0) begin
                    res_value <= value_t'({1'b0, supply_mv});
                    state     <= ST_EMIT;
                  end else if (cnt_next == '0) begin
                    res_status <= STAT_EMPTY;
                    state      <= ST_EMIT;
                  end else if (sum_next == '0) begin
                    // A reference reading of all zeros pins the supply at full scale.
                    supply_mv <= SUPPLY_MAX;
                    res_value <= VALUE_MAX;
                    state     <= ST_EMIT;
                  end else begin
                    state <= ST_MUL;
                  end
                end else begin
                  if (cnt_next == '0) begin
                    res_status <= STAT_EMPTY;
                    state      <= ST_EMIT;
                  end else if (supply_mv == '0) begin
                    res_status <= STAT_NO_SUPPLY;
                    state      <= ST_EMIT;
                  end else if (span == '0) begin
                    res_status <= STAT_SPAN_ZERO;
                    state      <= ST_EMIT;
                  end else begin
                    state <= ST_MUL;
                  end
                end
              end
            end
          end
        end
        ST_MUL: begin
          prod  <= mul_p;
          mstep <= mstep + 3'd1;
          if (md == MODE_TEMP && mstep == 3'd1) begin
            acc_a <= prod[31:0];
          end
          if (md == MODE_TEMP && mstep == 3'd3) begin
            acc_b <= prod[DEN_W-1:0];
          end
          if (mstep == mstep_last) begin
            state <= ST_COMB;
          end
        end
        ST_COMB: begin
          if (md == MODE_BATT || md == MODE_SOLAR) begin
            res_value <= value_t'({1'b0, lin_sat});
            state     <= ST_EMIT;
          end else if (md == MODE_REF) begin
            num_reg <= $signed(DIV_UW'(prod[DEN_W-1:0]));
            den_reg <= DEN_W'(wsum);
            state   <= ST_PREP;
          end else begin
            num_reg <= num_temp;
            den_reg <= prod[DEN_W-1:0];
            state   <= ST_PREP;
          end
        end
        ST_PREP: begin
          // Floor division of a negative value works on its one's complement.
          neg_reg <= big_n[DIV_UW-1];
          u_reg   <= big_n[DIV_UW-1] ? ~big_n : big_n;
          d_reg   <= {den_reg, 1'b0};
          state   <= ST_DIVGO;
        end
        ST_DIVGO: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_res.done) begin
            if (md == MODE_REF) begin
              supply_mv <= ref_mv;
              res_value <= value_t'({1'b0, ref_mv});
            end else begin
              res_value <= t_sat;
            end
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_kind   <= res_kind;
            out_value  <= res_value;
            out_status <= res_status;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid  = out_valid;
  assign out_ch.kind   = out_kind;
  assign out_ch.value  = out_value;
  assign out_ch.status = out_status;

  `AVTC_ASSERT_NEXT(a_supply_hold, clk, rst, supply_mv != '0, supply_mv == $past(supply_mv), "measured supply changed")
  `AVTC_ASSERT(a_cnt_limit, clk, rst, kept_count <= CNT_LIMIT, "kept sample count beyond burst limit")
  `AVTC_ASSERT(a_err_value, clk, rst, out_valid && out_status != STAT_OK |-> out_value == '0, "error result with nonzero value")
  `AVTC_ASSERT(a_done_in_div, clk, rst, div_res.done |-> state == ST_DIV, "divide finished outside its wait state")

endmodule

FILE: tb/adc_vdd_temp_calibration_tb.sv
module adc_vdd_temp_calibration_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import avtc_pkg::*;

  localparam int MAX_BURST     = 16;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct packed {
    mode_t   kind;
    value_t  value;
    status_t status;
  } reading_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     cfg_we;
  reg_idx_t cfg_index;
  reg_t     cfg_data;

  avtc_in_if  in_ch ();
  avtc_out_if out_ch ();

  adc_vdd_temp_calibration #(.MAX_BURST(MAX_BURST)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Calibration registers and conversion state as the block should hold them.
  reg_t        vref_cal_m;
  reg_t        temp_lo_m;
  reg_t        temp_hi_m;
  reg_t        batt_gain_m;
  supply_t     supply_m;
  logic [15:0] burst_sum_m;
  logic [4:0]  kept_m;
  bit          burst_open_m;
  mode_t       burst_mode_m;

  reading_t pending_readings[$];

  int items_sent    = 0;
  int settings_used = 0;
  int mismatches    = 0;
  int hold_left     = 0;
  int stall_window  = 0;
  int stall_pct     = 0;
  int burst_left    = 0;
  int cycle_count   = 0;
  bit no_gaps       = 1'b0;
  int kind_seen[4];
  int status_seen[4];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint nearest_div(longint n, longint d);
    longint a;
    longint b;
    longint q;
    a = 2 * n + d;
    b = 2 * d;
    q = a / b;
    if (a % b != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp_value(longint v);
    if (v > VALUE_MAX) return VALUE_MAX;
    if (v < VALUE_MIN) return VALUE_MIN;
    return v;
  endfunction

  function automatic void expect_reading(mode_t k, longint v, status_t st);
    reading_t r;
    r.kind   = k;
    r.value  = v[VALUE_W-1:0];
    r.status = st;
    pending_readings.push_back(r);
  endfunction

  function automatic void predict_conversion(mode_t m, sample_t s, logic last);
    longint sup;
    longint tot;
    longint cnt;
    longint span;
    longint mv;
    longint num;
    longint den;
    sup = supply_m;
    if (m == MODE_BATT || m == MODE_SOLAR) begin
      if (supply_m == 0) begin
        expect_reading(m, 0, STAT_NO_SUPPLY);
        return;
      end
      if (m == MODE_BATT) begin
        mv = (longint'(s) * longint'(batt_gain_m) * sup + (64'sd1 <<< (BATT_SHIFT - 1)))
             >>> BATT_SHIFT;
      end else begin
        mv = (longint'(s) * sup + (64'sd1 <<< (SOLAR_SHIFT - 1))) >>> SOLAR_SHIFT;
      end
      expect_reading(m, clamp_value(mv), STAT_OK);
      return;
    end

    // A sample with no burst open, or of the other burst kind, starts afresh and is thrown away as the first.
    if (!burst_open_m || burst_mode_m != m) begin
      burst_open_m = 1'b1;
      burst_mode_m = m;
      burst_sum_m  = '0;
      kept_m       = '0;
    end else if (kept_m < MAX_BURST - 1) begin
      burst_sum_m = burst_sum_m + s;
      kept_m      = kept_m + 1;
    end
    if (!last) return;

    tot = burst_sum_m;
    cnt = kept_m;
    burst_open_m = 1'b0;
    burst_sum_m  = '0;
    kept_m       = '0;

    if (m == MODE_REF) begin
      if (supply_m != 0) begin
        expect_reading(MODE_REF, sup, STAT_OK);
      end else if (cnt == 0) begin
        expect_reading(MODE_REF, 0, STAT_EMPTY);
      end else begin
        if (tot == 0) begin
          mv = SUPPLY_MAX;
        end else begin
          mv = nearest_div(longint'(K_CAL_MV) * longint'(vref_cal_m) * cnt, tot);
          if (mv > SUPPLY_MAX) mv = SUPPLY_MAX;
        end
        supply_m = mv[SUPPLY_W-1:0];
        expect_reading(MODE_REF, mv, STAT_OK);
      end
      return;
    end

    span = longint'(temp_hi_m) - longint'(temp_lo_m);
    if (cnt == 0) begin
      expect_reading(MODE_TEMP, 0, STAT_EMPTY);
    end else if (supply_m == 0) begin
      expect_reading(MODE_TEMP, 0, STAT_NO_SUPPLY);
    end else if (span == 0) begin
      expect_reading(MODE_TEMP, 0, STAT_SPAN_ZERO);
    end else begin
      num = 1280 * (sup * tot - longint'(K_CAL_MV) * cnt * longint'(temp_lo_m));
      den = longint'(K_CAL_MV) * cnt * span;
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      expect_reading(MODE_TEMP, clamp_value(longint'(T_OFFSET) + nearest_div(num, den)), STAT_OK);
    end
  endfunction

  function automatic sample_t pick_sample(mode_t m);
    longint lo;
    longint hi;
    longint raw;
    if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    if (m != MODE_TEMP || supply_m == 0 || $urandom_range(0, 3) == 0)
      return sample_t'($urandom_range(0, 4095));
    lo = temp_lo_m;
    hi = temp_hi_m;
    // Aim the sensor reading between the two calibration points, a little past either end,
    // then turn it back into the raw reading that the measured supply would give.
    raw = lo + ((hi - lo) * longint'($urandom_range(0, 24))) / 16 - (hi - lo) / 4;
    raw = raw * 3000 / longint'(supply_m) + longint'($urandom_range(0, 16)) - 8;
    if (raw < 0) raw = 0;
    if (raw > 4095) raw = 4095;
    return sample_t'(raw);
  endfunction

  task automatic send_sample(mode_t m, sample_t s, logic last);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.sample    <= s;
    in_ch.burst_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_conversion(m, s, last);
    items_sent++;
    if (!no_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(0, 12);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_burst(mode_t m, int len);
    for (int i = 0; i < len; i++) send_sample(m, pick_sample(m), i == len - 1);
  endtask

  // Wait until every reading has come back, then give a burst sample that makes no
  // reading time to finish as well.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, reg_t d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_VREF_CAL:  vref_cal_m  = d;
      REG_TEMP_LO:   temp_lo_m   = d;
      REG_TEMP_HI:   temp_hi_m   = d;
      REG_BATT_GAIN: batt_gain_m = d;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_unmeasured_supply();
    send_sample(MODE_BATT, 12'd4095, 1'b1);
    send_sample(MODE_SOLAR, 12'd0, 1'b0);
    send_sample(MODE_TEMP, 12'd5, 1'b0);
    send_sample(MODE_TEMP, 12'd4095, 1'b1);
    send_sample(MODE_TEMP, 12'd100, 1'b1);
    send_sample(MODE_REF, 12'd200, 1'b1);
    settle_block();
    // A zero calibration gives a zero supply, which leaves the supply unmeasured.
    write_reg(REG_VREF_CAL, '0);
    send_sample(MODE_REF, 12'd1, 1'b0);
    send_sample(MODE_REF, 12'd4095, 1'b1);
    send_sample(MODE_BATT, 12'd1234, 1'b0);
  endtask

  task automatic test_supply_measurement();
    int variant;
    sample_t s;
    variant = $urandom_range(0, 7);
    settle_block();
    write_reg(REG_VREF_CAL, (variant == 1) ? reg_t'(4095) : RST_VREF_CAL);
    send_sample(MODE_TEMP, 12'd300, 1'b0);
    send_sample(MODE_REF, 12'd4095, 1'b0);
    send_sample(MODE_BATT, 12'd2000, 1'b1);
    // Either an all-zero burst, a tiny one that saturates, or a plausible supply of 5 V.
    for (int i = 0; i < 3; i++) begin
      case (variant)
        0: s = '0;
        1: s = sample_t'($urandom_range(1, 4));
        default: s = sample_t'($urandom_range(900, 1100));
      endcase
      send_sample(MODE_REF, s, i == 2);
    end
    send_sample(MODE_SOLAR, 12'd4095, 1'b0);
    send_sample(MODE_REF, 12'd77, 1'b1);
  endtask

  task automatic test_conversion_extremes();
    settle_block();
    write_reg(REG_BATT_GAIN, 12'd4095);
    write_reg(REG_VREF_CAL, 12'd4095);
    send_sample(MODE_BATT, 12'd4095, 1'b0);
    send_sample(MODE_BATT, 12'd0, 1'b1);
    settle_block();
    write_reg(REG_BATT_GAIN, '0);
    send_sample(MODE_BATT, 12'd4095, 1'b0);
    send_sample(MODE_SOLAR, 12'd4095, 1'b1);
  endtask

  task automatic test_temperature_cases();
    settle_block();
    write_reg(REG_TEMP_LO, 12'd1000);
    write_reg(REG_TEMP_HI, 12'd1000);
    send_sample(MODE_TEMP, 12'd1234, 1'b0);
    send_sample(MODE_TEMP, 12'd1000, 1'b1);
    settle_block();
    write_reg(REG_TEMP_LO, '0);
    write_reg(REG_TEMP_HI, 12'd4095);
    send_sample(MODE_TEMP, 12'd0, 1'b0);
    send_sample(MODE_TEMP, 12'd4095, 1'b0);
    send_sample(MODE_TEMP, 12'd0, 1'b1);
    settle_block();
    write_reg(REG_TEMP_LO, 12'd900);
    write_reg(REG_TEMP_HI, 12'd600);
    send_burst(MODE_TEMP, 3);
  endtask

  task automatic test_backpressure();
    mode_t m;
    settle_block();
    no_gaps = 1'b1;
    // Hold the output off for long enough that the block stalls its input with work pending.
    hold_left <= 400;
    for (int i = 0; i < 20; i++) begin
      m = mode_t'($urandom_range(1, 3));
      send_sample(m, pick_sample(m), 1'b1);
    end
    no_gaps = 1'b0;
    settle_block();
  endtask

  task automatic test_random_traffic();
    int target;
    int chunk_end;
    int len;
    int r;
    mode_t m;
    mode_t other;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      settle_block();
      case ($urandom_range(0, 4))
        0: begin
          write_reg(REG_TEMP_LO, '0);
          write_reg(REG_TEMP_HI, 12'd4095);
        end
        1: begin
          write_reg(REG_TEMP_LO, 12'd4095);
          write_reg(REG_TEMP_HI, '0);
        end
        2: begin
          r = $urandom_range(0, 4095);
          write_reg(REG_TEMP_LO, reg_t'(r));
          write_reg(REG_TEMP_HI, reg_t'(r));
        end
        3: begin
          r = $urandom_range(0, 4094);
          write_reg(REG_TEMP_LO, reg_t'(r));
          write_reg(REG_TEMP_HI, reg_t'(r + 1));
        end
        default: begin
          r = $urandom_range(200, 1200);
          write_reg(REG_TEMP_LO, reg_t'(r));
          write_reg(REG_TEMP_HI, reg_t'(r + $urandom_range(50, 900)));
        end
      endcase
      r = $urandom_range(0, 2);
      write_reg(REG_VREF_CAL, (r == 0) ? '0 : (r == 1) ? '1 : reg_t'($urandom_range(0, 4095)));
      r = $urandom_range(0, 2);
      write_reg(REG_BATT_GAIN, (r == 0) ? '0 : (r == 1) ? '1 : reg_t'($urandom_range(0, 4095)));
      settings_used++;
      no_gaps   = ($urandom_range(0, 3) == 0);
      chunk_end = items_sent + $urandom_range(100, 200);

      while (items_sent < chunk_end) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
        r   = $urandom_range(0, 19);
        if (r < 7) begin
          send_burst(MODE_TEMP, len);
        end else if (r < 10) begin
          send_burst(MODE_REF, len);
        end else if (r < 14) begin
          m = ($urandom_range(0, 1) != 0) ? MODE_BATT : MODE_SOLAR;
          send_sample(m, pick_sample(m), $urandom_range(0, 1));
        end else if (r < 16) begin
          // An unfinished burst abandoned when the other kind turns up.
          m     = ($urandom_range(0, 1) != 0) ? MODE_REF : MODE_TEMP;
          other = (m == MODE_REF) ? MODE_TEMP : MODE_REF;
          for (int i = 0; i < $urandom_range(1, 4); i++) send_sample(m, pick_sample(m), 1'b0);
          send_burst(other, len);
        end else if (r < 17) begin
          m     = ($urandom_range(0, 1) != 0) ? MODE_REF : MODE_TEMP;
          other = ($urandom_range(0, 1) != 0) ? MODE_BATT : MODE_SOLAR;
          send_sample(m, pick_sample(m), 1'b0);
          send_sample(other, pick_sample(other), $urandom_range(0, 1));
          send_burst(m, len);
        end else begin
          m = mode_t'($urandom_range(0, 3));
          send_sample(m, sample_t'($urandom_range(0, 4095)), $urandom_range(0, 1));
        end
      end
    end
  endtask

  // Output side: long hold-offs on request, otherwise a stall rate that changes now and then.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      if (stall_window == 0) begin
        stall_pct    <= 30 * $urandom_range(0, 3);
        stall_window <= $urandom_range(20, 120);
      end else begin
        stall_window <= stall_window - 1;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_readings
    reading_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      kind_seen[out_ch.kind]++;
      status_seen[out_ch.status]++;
      if (pending_readings.size() == 0) begin
        mismatches++;
        $display("%0t: reading with none pending: kind %0d value %0d status %0d",
                 $time, out_ch.kind, out_ch.value, out_ch.status);
      end else begin
        want = pending_readings.pop_front();
        if (out_ch.kind !== want.kind || out_ch.value !== want.value ||
            out_ch.status !== want.status) begin
          mismatches++;
          if (mismatches <= 20)
            $display("%0t: expected kind %0d value %0d status %0d, got kind %0d value %0d status %0d",
                     $time, want.kind, want.value, want.status,
                     out_ch.kind, out_ch.value, out_ch.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d readings outstanding",
               cycle_count, pending_readings.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = REG_VREF_CAL;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_REF;
    in_ch.sample    = '0;
    in_ch.burst_end = 1'b0;
    out_ch.ready    = 1'b0;
    vref_cal_m      = RST_VREF_CAL;
    temp_lo_m       = RST_TEMP_LO;
    temp_hi_m       = RST_TEMP_HI;
    batt_gain_m     = RST_BATT_GAIN;
    supply_m        = '0;
    burst_sum_m     = '0;
    kept_m          = '0;
    burst_open_m    = 1'b0;
    burst_mode_m    = MODE_REF;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unmeasured_supply();
    test_supply_measurement();
    test_conversion_extremes();
    test_temperature_cases();
    test_backpressure();
    test_random_traffic();
    settle_block();

    $display("Sent %0d samples over %0d random register settings, measured supply %0d mV.",
             items_sent, settings_used, supply_m);
    $display("Readings: supply %0d, temperature %0d, battery %0d, solar %0d; %0d empty, %0d no supply, %0d zero span.",
             kind_seen[MODE_REF], kind_seen[MODE_TEMP], kind_seen[MODE_BATT],
             kind_seen[MODE_SOLAR], status_seen[STAT_EMPTY], status_seen[STAT_NO_SUPPLY],
             status_seen[STAT_SPAN_ZERO]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
